// ===== rtl/ready_queue_priority_scheduler_unit_macros.svh =====
// assertion macros shared by the checker
`ifndef READY_QUEUE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define READY_QUEUE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define RQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication with consequent in the next cycle
`define RQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rqps_pkg.sv =====
package rqps_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 16;

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_POP_FRONT = 3'd2,
        OP_POP_REAR  = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR = 3'd5,
        OP_TICK      = 3'd6,
        OP_NONE      = 3'd7
    } opcode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [7:0]  priority_val;
        logic [15:0] arrival;
        logic [15:0] run_left;
        logic [15:0] waited;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } mem_ctl_t;
endpackage

// ===== rtl/rqps_ram.sv =====
module rqps_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== rtl/rqps_ctrl.sv =====
module rqps_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  opcode,
    input  logic [7:0]                  task_id,
    input  logic [7:0]                  task_priority,
    input  logic [15:0]                 arrival_time,
    input  logic [15:0]                 run_time_left,
    output rqps_pkg::mem_ctl_t          mem_ctl,
    output rqps_pkg::entry_t            wr_data,
    input  rqps_pkg::entry_t            rd_data,
    output logic                        done,
    output logic [1:0]                  status,
    output rqps_pkg::entry_t            out_entry,
    output logic [4:0]                  entry_count,
    output logic [19:0]                 sum_run_time_left
);
    import rqps_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_TICK   = 6'b001000,
        S_REPORT = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;
    entry_t new_reg, new_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic rd_pend_reg, rd_pend_next;
    logic [1:0] status_reg, status_next;
    entry_t out_reg, out_next;
    logic done_reg, done_next;
    logic key_gt;

    assign key_gt = (rd_data.priority_val > new_reg.priority_val) ||
                    ((rd_data.priority_val == new_reg.priority_val) &&
                     (rd_data.arrival > new_reg.arrival));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            sum_reg     <= '0;
            done_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            sum_reg     <= sum_next;
            done_reg    <= done_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        new_reg    <= new_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        new_next     = new_reg;
        occ_next     = occ_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        rd_pend_next = 1'b0;
        status_next  = status_reg;
        out_next     = out_reg;
        done_next    = 1'b0;
        mem_ctl      = '0;
        wr_data      = rd_data;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = opcode;
                    new_next.task_id = task_id;
                    new_next.priority_val = task_priority;
                    new_next.arrival = arrival_time;
                    new_next.run_left = run_time_left;
                    new_next.waited = '0;
                    status_next = ST_OK;
                    out_next = '0;
                    case (opcode)
                        OP_APPEND, OP_INSERT:
                        begin
                            if (occ_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next = S_DONE;
                            end
                            else if (opcode == OP_APPEND || occ_reg == '0)
                            begin
                                pos_next = occ_reg;
                                idx_next = occ_reg;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                idx_next = '0;
                                pos_next = occ_reg;
                                mem_ctl.rd_en = 1'b1;
                                mem_ctl.rd_addr = '0;
                                rd_pend_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                if (opcode == OP_POP_REAR || opcode == OP_PEEK_REAR)
                                begin
                                    mem_ctl.rd_addr = IDX_W'(occ_reg - 1'b1);
                                end
                                else
                                begin
                                    mem_ctl.rd_addr = '0;
                                end
                                idx_next = '0;
                                state_next = S_REPORT;
                            end
                        end
                        OP_TICK:
                        begin
                            if (occ_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next = '0;
                                mem_ctl.rd_en = 1'b1;
                                mem_ctl.rd_addr = '0;
                                rd_pend_next = 1'b1;
                                state_next = S_TICK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (key_gt)
                begin
                    pos_next = idx_reg;
                    idx_next = occ_reg;
                    state_next = S_SHIFT;
                end
                else if (idx_reg + 1'b1 == occ_reg)
                begin
                    idx_next = occ_reg;
                    state_next = S_SHIFT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    mem_ctl.rd_en = 1'b1;
                    mem_ctl.rd_addr = IDX_W'(idx_reg + 1'b1);
                    rd_pend_next = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // idx walks down from occupancy; read idx-1, then write idx
                if (rd_pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_ctl.wr_addr = IDX_W'(idx_reg);
                    wr_data = rd_data;
                    idx_next = idx_reg - 1'b1;
                end
                else if (idx_reg == pos_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_ctl.wr_addr = IDX_W'(idx_reg);
                    wr_data = new_reg;
                    occ_next = occ_reg + 1'b1;
                    sum_next = sum_reg + SUM_W'(new_reg.run_left);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_ctl.rd_addr = IDX_W'(idx_reg - 1'b1);
                    rd_pend_next = 1'b1;
                end
            end
            S_TICK:
            begin
                if (rd_pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_ctl.wr_addr = IDX_W'(idx_reg);
                    wr_data = rd_data;
                    if (rd_data.waited != 16'hFFFF)
                    begin
                        wr_data.waited = rd_data.waited + 16'd1;
                    end
                    if (idx_reg + 1'b1 == occ_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_ctl.rd_addr = IDX_W'(idx_reg);
                    rd_pend_next = 1'b1;
                end
            end
            S_REPORT:
            begin
                // idx 0: capture report; pop front then moves slots down
                if (idx_reg == '0)
                begin
                    out_next = rd_data;
                    if (op_reg == OP_POP_FRONT)
                    begin
                        occ_next = occ_reg - 1'b1;
                        sum_next = sum_reg - SUM_W'(rd_data.run_left);
                        if (occ_reg == CNT_W'(1))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next = CNT_W'(1);
                            mem_ctl.rd_en = 1'b1;
                            mem_ctl.rd_addr = IDX_W'(1);
                            rd_pend_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (op_reg == OP_POP_REAR)
                        begin
                            occ_next = occ_reg - 1'b1;
                            sum_next = sum_reg - SUM_W'(rd_data.run_left);
                        end
                        state_next = S_DONE;
                    end
                end
                else if (rd_pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_ctl.wr_addr = IDX_W'(idx_reg - 1'b1);
                    wr_data = rd_data;
                    if (idx_reg == occ_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_ctl.rd_addr = IDX_W'(idx_reg);
                    rd_pend_next = 1'b1;
                end
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = status_reg;
    assign out_entry = out_reg;
    assign entry_count = 5'(occ_reg);
    assign sum_run_time_left = 20'(sum_reg);
endmodule

// ===== rtl/ready_queue_priority_scheduler_unit.sv =====
// Ready queue of up to 16 entries kept in one synchronous RAM, one
// slot per entry, front at slot 0. An item is taken at the edge where start is
// high and busy is low. Its result is shown for one cycle with done high and
// cannot be held off. Full, empty and unused opcodes, and a tick on an empty
// queue, finish without touching the RAM. Append writes at the rear slot. An
// insert scans one slot a cycle for its place in priority order and then
// shifts each later slot with a read and then a write. Pop front moves each
// later slot down the same way, and a tick reads and rewrites every slot.
// All of it runs through the single RAM port pair.
module ready_queue_priority_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [7:0]  task_id,
    input  logic [7:0]  task_priority,
    input  logic [15:0] arrival_time,
    input  logic [15:0] run_time_left,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  out_task_id,
    output logic [7:0]  out_priority,
    output logic [15:0] out_arrival,
    output logic [15:0] out_run_time_left,
    output logic [15:0] out_waited,
    output logic [4:0]  entry_count,
    output logic [19:0] sum_run_time_left
);
    import rqps_pkg::*;

    mem_ctl_t mem_ctl;
    entry_t wr_data, rd_data, out_entry;

    rqps_ctrl u_ctrl (
        .clk, .rst_n, .start, .busy, .opcode, .task_id, .task_priority,
        .arrival_time, .run_time_left, .mem_ctl, .wr_data, .rd_data, .done,
        .status, .out_entry, .entry_count, .sum_run_time_left
    );

    rqps_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_ram (
        .clk,
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (mem_ctl.rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (mem_ctl.wr_addr),
        .wr_data (wr_data)
    );

    assign out_task_id = out_entry.task_id;
    assign out_priority = out_entry.priority_val;
    assign out_arrival = out_entry.arrival;
    assign out_run_time_left = out_entry.run_left;
    assign out_waited = out_entry.waited;
endmodule

// ===== rtl/rqps_checker.sv =====
`include "ready_queue_priority_scheduler_unit_macros.svh"

module rqps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [7:0]  out_task_id,
    input logic [4:0]  entry_count
);
    import rqps_pkg::*;

    `RQ_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `RQ_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !done)
    `RQ_ASSERT_IMPL(a_err_zero, clk, rst_n, done && status != ST_OK, out_task_id == 8'd0)
    `RQ_ASSERT_IMPL(a_full_count, clk, rst_n, done && status == ST_FULL,
        entry_count == 5'(QUEUE_DEPTH))
endmodule

bind ready_queue_priority_scheduler_unit rqps_checker u_chk (
    .clk, .rst_n, .start, .busy, .done, .status, .out_task_id, .entry_count
);

// ===== bench/ready_queue_priority_scheduler_unit_tb.sv =====
module ready_queue_priority_scheduler_unit_tb;
    import rqps_pkg::*;

    typedef struct packed {
        opcode_t     op;
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] arr;
        logic [15:0] run;
        logic        hold;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] arr;
        logic [15:0] run;
        logic [15:0] waited;
        logic [4:0]  cnt;
        logic [19:0] sum;
    } reply_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  opcode = '0;
    logic [7:0]  task_id = '0;
    logic [7:0]  task_priority = '0;
    logic [15:0] arrival_time = '0;
    logic [15:0] run_time_left = '0;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  out_task_id;
    logic [7:0]  out_priority;
    logic [15:0] out_arrival;
    logic [15:0] out_run_time_left;
    logic [15:0] out_waited;
    logic [4:0]  entry_count;
    logic [19:0] sum_run_time_left;

    cmd_t   pending_cmds[$];
    reply_t expected_replies[$];
    entry_t ready_model[$];
    int     errors = 0;
    int     sent = 0;
    int     replies_seen = 0;
    int     gap = 0;
    int     idle_cycles = 0;
    bit     feeding_done = 0;
    bit     drain_wait = 0;

    ready_queue_priority_scheduler_unit uut (.*);

    always #2 clk = ~clk;

    function automatic reply_t predict_queue(cmd_t c);
        reply_t r;
        entry_t e;
        int pos;
        r = '0;
        case (c.op)
            OP_APPEND, OP_INSERT:
            begin
                if (ready_model.size() >= QUEUE_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    e = '{task_id: c.id, priority_val: c.prio, arrival: c.arr,
                          run_left: c.run, waited: 16'd0};
                    pos = ready_model.size();
                    if (c.op == OP_INSERT)
                        for (int i = 0; i < ready_model.size(); i++)
                            if (ready_model[i].priority_val > c.prio ||
                                (ready_model[i].priority_val == c.prio &&
                                 ready_model[i].arrival > c.arr))
                            begin
                                pos = i;
                                break;
                            end
                    ready_model.insert(pos, e);
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR:
            begin
                if (ready_model.size() == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    if (c.op == OP_POP_FRONT || c.op == OP_PEEK_FRONT)
                        e = ready_model[0];
                    else
                        e = ready_model[ready_model.size() - 1];
                    r.id = e.task_id;
                    r.prio = e.priority_val;
                    r.arr = e.arrival;
                    r.run = e.run_left;
                    r.waited = e.waited;
                    if (c.op == OP_POP_FRONT)
                        void'(ready_model.pop_front());
                    else if (c.op == OP_POP_REAR)
                        void'(ready_model.pop_back());
                end
            end
            OP_TICK:
                foreach (ready_model[i])
                    if (ready_model[i].waited != 16'hFFFF)
                        ready_model[i].waited = ready_model[i].waited + 16'd1;
            default:
                ;
        endcase
        r.cnt = 5'(ready_model.size());
        foreach (ready_model[i])
            r.sum = r.sum + ready_model[i].run_left;
        return r;
    endfunction

    function automatic cmd_t make_cmd(opcode_t op, logic [7:0] id, logic [7:0] p,
                                      logic [15:0] a, logic [15:0] t);
        cmd_t c;
        c.op = op;
        c.id = id;
        c.prio = p;
        c.arr = a;
        c.run = t;
        c.hold = 1'b0;
        return c;
    endfunction

    function automatic cmd_t random_cmd(int fill_bias);
        int pick;
        opcode_t op;
        pick = $urandom_range(0, 99);
        if (pick < fill_bias)
            op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND;
        else if (pick < 80)
            op = opcode_t'($urandom_range(2, 5));
        else if (pick < 95)
            op = OP_TICK;
        else
            op = OP_NONE;
        return make_cmd(op, 8'($urandom), 8'($urandom_range(0, 7) * 36),
                        16'($urandom_range(0, 15) * 4369), 16'($urandom));
    endfunction

    initial
    begin
        cmd_t c;
        pending_cmds.push_back(make_cmd(OP_POP_FRONT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PEEK_REAR, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_POP_REAR, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PEEK_FRONT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_APPEND, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_INSERT, 8'h00, 8'h00, 16'h0000, 16'h0000));
        pending_cmds.push_back(make_cmd(OP_INSERT, 8'h11, 8'h80, 16'h0010, 16'h1234));
        pending_cmds.push_back(make_cmd(OP_INSERT, 8'h22, 8'h80, 16'h0010, 16'h4321));
        pending_cmds.push_back(make_cmd(OP_INSERT, 8'h33, 8'h80, 16'h0005, 16'h00AA));
        pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PEEK_FRONT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PEEK_REAR, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_POP_FRONT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_POP_REAR, 0, 0, 0, 0));
        for (int i = 0; i < 14; i++)
            pending_cmds.push_back(make_cmd(OP_APPEND, 8'(i), 8'(255 - i), 16'(i), 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_INSERT, 8'hAA, 8'h01, 16'h0001, 16'h0001));
        pending_cmds.push_back(make_cmd(OP_APPEND, 8'hBB, 8'h02, 16'h0002, 16'h0002));
        c = make_cmd(OP_INSERT, 8'hCC, 8'h03, 16'h0003, 16'h0003);
        c.hold = 1'b1;
        pending_cmds.push_back(c);
        for (int i = 0; i < 40; i++)
            pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_POP_FRONT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PEEK_REAR, 0, 0, 0, 0));
        for (int i = 0; i < 400; i++)
        begin
            c = random_cmd((i / 100) % 2 == 0 ? 55 : 25);
            if (i % 97 == 0)
                c.hold = 1'b1;
            pending_cmds.push_back(c);
        end
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(make_cmd(OP_POP_REAR, 0, 0, 0, 0));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk)
    begin
        cmd_t c;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                c = pending_cmds.pop_front();
                expected_replies.push_back(predict_queue(c));
                sent <= sent + 1;
                drain_wait <= c.hold;
                gap <= $urandom_range(0, 3);
                start <= 1'b0;
            end
            else if (!start)
            begin
                if (pending_cmds.size() == 0)
                    feeding_done <= 1'b1;
                else if (drain_wait && expected_replies.size() != 0)
                    ;
                else if (gap > 0)
                    gap <= gap - 1;
                else
                begin
                    drain_wait <= 1'b0;
                    c = pending_cmds[0];
                    opcode <= c.op;
                    task_id <= c.id;
                    task_priority <= c.prio;
                    arrival_time <= c.arr;
                    run_time_left <= c.run;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        reply_t exp;
        reply_t got;
        if (rst_n && done)
        begin
            got = '{status, out_task_id, out_priority, out_arrival, out_run_time_left,
                    out_waited, entry_count, sum_run_time_left};
            replies_seen <= replies_seen + 1;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors <= errors + 1;
            end
            else
            begin
                exp = expected_replies.pop_front();
                if (exp.st != got.st || exp.id != got.id || exp.prio != got.prio ||
                    exp.arr != got.arr || exp.run != got.run ||
                    exp.waited != got.waited || exp.cnt != got.cnt || exp.sum != got.sum)
                begin
                    $display("%0t: mismatch exp st=%0d id=%h pr=%h arr=%h run=%h wt=%h cnt=%0d sum=%h",
                             $time, exp.st, exp.id, exp.prio, exp.arr, exp.run, exp.waited,
                             exp.cnt, exp.sum);
                    $display("%0t:          got st=%0d id=%h pr=%h arr=%h run=%h wt=%h cnt=%0d sum=%h",
                             $time, got.st, got.id, got.prio, got.arr, got.run, got.waited,
                             got.cnt, got.sum);
                    errors <= errors + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_replies.size());
            $display("ready_queue_priority_scheduler_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        wait (feeding_done);
        wait (expected_replies.size() == 0);
        repeat (200) @(posedge clk);
        $display("sent %0d items (fill, ordered insert, both-end pops and peeks, aging)",
                 sent);
        $display("checked %0d results, %0d errors", replies_seen, errors);
        if (errors == 0)
            $display("ready_queue_priority_scheduler_unit_tb: done, clean");
        else
            $display("ready_queue_priority_scheduler_unit_tb: done, errors");
        $finish;
    end
endmodule
